// File: sv/nco_pkg.sv
// nco package: widths, state type, control structs and the quarter-wave sine table
`timescale 1ns / 1ps
`default_nettype none
package nco_pkg;

  localparam int MAX_BLOCK       = 64;
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int OUT_BITS        = 16;
  localparam int TUNE_BITS       = 32;
  localparam int COUNT_BITS      = 7;
  localparam int PHASE_OUT_BITS  = 16;
  localparam int REM_BITS        = $clog2(MAX_BLOCK + 1);
  localparam int QUARTER         = 1 << TABLE_ADDR_BITS;
  localparam int STEP_UP         = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int STEP_DOWN       = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam longint unsigned AMP_MAX     = (64'd1 << (OUT_BITS - 1)) - 64'd1;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  typedef logic [OUT_BITS-1:0] qtab_t [0:QUARTER];

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic issue;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

  // shift and subtract quotient, used only while the table is built
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t            tab;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  t;
    longint unsigned  d;
    longint unsigned  s;
    longint unsigned  a;
    for (int i = 0; i <= QUARTER; i++) begin
      x  = (longint'(i) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int n = 8; n >= 1; n--) begin
        d = div_u64((x2 * t) >> 30, longint'((2 * n) * (2 * n + 1)));
        t = (d > ONE_Q30) ? 64'd0 : ONE_Q30 - d;
      end
      s = (x * t) >> 30;
      a = (s * AMP_MAX + (ONE_Q30 >> 1)) >> 30;
      if (a > AMP_MAX) begin
        a = AMP_MAX;
      end
      tab[i] = a[OUT_BITS-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage
`default_nettype wire

// File: sv/nco_if.sv
// nco channel interfaces: block request input and sample output
`timescale 1ns / 1ps
`default_nettype none
interface nco_in_if;
  logic                             valid;
  logic                             ready;
  logic [nco_pkg::COUNT_BITS-1:0]   sample_count;

  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

interface nco_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [nco_pkg::PHASE_OUT_BITS-1:0] phase_out;
  logic signed [nco_pkg::OUT_BITS-1:0]      cos_out;
  logic signed [nco_pkg::OUT_BITS-1:0]      sin_out;
  logic                                     last;

  modport source (output valid, output phase_out, output cos_out, output sin_out,
                  output last, input ready);
  modport sink   (input valid, input phase_out, input cos_out, input sin_out,
                  input last, output ready);
endinterface
`default_nettype wire

// File: sv/nco_phase_and_iq_generator.sv
// nco top level: block request in, phase and iq samples out
// Numerically controlled oscillator. Write the 32-bit signed tuning word (phase step
// per sample, frequency over sample rate times 2^32) through cfg_wr_en / cfg_wr_data
// while the block is idle. Each transfer on in_ch requests sample_count samples (counts
// above 64 give 64, zero gives none); each sample leaves on out_ch with the 16-bit
// phase, Q1.15 cosine and sine from a 1025-entry quarter-wave table, and last on the
// final one. A request of N samples occupies the block from the accept cycle through its
// N sample issues, one sample issue per cycle while the output slot is free, as set by
// the phase accumulator loop and the registered table read; each sample is presented in
// the cycle after its issue, and the next request is taken in the cycle after the last
// sample is issued. Output stalls hold the sequence without loss.
`timescale 1ns / 1ps
`default_nettype none
module nco_phase_and_iq_generator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [nco_pkg::TUNE_BITS-1:0]  cfg_wr_data,
  nco_in_if.sink                              in_ch,
  nco_out_if.source                           out_ch
);

  nco_pkg::dp_cmd_t    cmd;
  nco_pkg::dp_status_t status;

  nco_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .status (status),
    .cmd    (cmd)
  );

  nco_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// File: sv/nco_ctrl.sv
// nco controller: takes block requests and sequences one sample issue per cycle while the datapath slot is free
`timescale 1ns / 1ps
`default_nettype none
module nco_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  nco_in_if.sink            in_ch,
  input  nco_pkg::dp_status_t status,
  output nco_pkg::dp_cmd_t    cmd
);

  nco_pkg::ctrl_state_t             state;
  nco_pkg::ctrl_state_t             state_next;
  logic [nco_pkg::REM_BITS-1:0]     remaining;
  logic [nco_pkg::REM_BITS-1:0]     remaining_next;
  logic [nco_pkg::REM_BITS-1:0]     count_sat;

  always_comb begin
    if (in_ch.sample_count > nco_pkg::COUNT_BITS'(nco_pkg::MAX_BLOCK)) begin
      count_sat = nco_pkg::REM_BITS'(nco_pkg::MAX_BLOCK);
    end else begin
      count_sat = nco_pkg::REM_BITS'(in_ch.sample_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nco_pkg::ST_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    in_ch.ready    = 1'b0;
    cmd.issue      = 1'b0;
    cmd.last       = 1'b0;
    unique case (state)
      nco_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && (count_sat != '0)) begin
          remaining_next = count_sat;
          state_next     = nco_pkg::ST_RUN;
        end
      end
      nco_pkg::ST_RUN: begin
        cmd.last = (remaining == nco_pkg::REM_BITS'(1));
        if (status.slot_free) begin
          cmd.issue      = 1'b1;
          remaining_next = remaining - nco_pkg::REM_BITS'(1);
          if (cmd.last) begin
            state_next = nco_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = nco_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/nco_dp.sv
// nco datapath: phase accumulator, quarter-wave table lookup and output register
`timescale 1ns / 1ps
`default_nettype none
module nco_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [nco_pkg::TUNE_BITS-1:0]   cfg_wr_data,
  input  nco_pkg::dp_cmd_t                     cmd,
  output nco_pkg::dp_status_t                  status,
  nco_out_if.source                            out_ch
);

  localparam int TAB = nco_pkg::TABLE_ADDR_BITS;
  localparam int PB  = nco_pkg::PHASE_BITS;
  localparam int OB  = nco_pkg::OUT_BITS;

  logic [nco_pkg::TUNE_BITS-1:0]          tuning_word;
  logic [PB-1:0]                          phase_acc;
  logic [PB+nco_pkg::TUNE_BITS-1:0]       tw_wide;
  logic [PB+nco_pkg::TUNE_BITS-1:0]       tw_scaled;
  logic [PB-1:0]                          step;
  logic [TAB+1:0]                         k;
  logic [1:0]                             q_sin;
  logic [1:0]                             q_cos;
  logic [TAB-1:0]                         r;
  logic [TAB:0]                           sin_idx;
  logic [TAB:0]                           cos_idx;

  logic                                   valid;
  logic                                   last;
  logic [nco_pkg::PHASE_OUT_BITS-1:0]     phase;
  logic [OB-1:0]                          sin_mag;
  logic [OB-1:0]                          cos_mag;
  logic                                   sin_neg;
  logic                                   cos_neg;

  // sign extend, then scale to the accumulator width
  assign tw_wide   = {{PB{tuning_word[nco_pkg::TUNE_BITS-1]}}, tuning_word};
  assign tw_scaled = (tw_wide << nco_pkg::STEP_UP) >> nco_pkg::STEP_DOWN;
  assign step      = tw_scaled[PB-1:0];

  assign k     = phase_acc[PB-1 -: TAB+2];
  assign q_sin = k[TAB+1:TAB];
  assign q_cos = q_sin + 2'd1;
  assign r     = k[TAB-1:0];

  always_comb begin
    if (q_sin[0]) begin
      sin_idx = (TAB+1)'(nco_pkg::QUARTER) - {1'b0, r};
    end else begin
      sin_idx = {1'b0, r};
    end
    if (q_cos[0]) begin
      cos_idx = (TAB+1)'(nco_pkg::QUARTER) - {1'b0, r};
    end else begin
      cos_idx = {1'b0, r};
    end
  end

  assign status.slot_free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuning_word <= '0;
    end else if (cfg_wr_en) begin
      tuning_word <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      valid     <= 1'b0;
    end else begin
      if (cmd.issue) begin
        phase_acc <= phase_acc + step;
        valid     <= 1'b1;
      end else if (out_ch.ready) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      phase   <= phase_acc[PB-1 -: nco_pkg::PHASE_OUT_BITS];
      sin_mag <= nco_pkg::QTAB[sin_idx];
      cos_mag <= nco_pkg::QTAB[cos_idx];
      sin_neg <= q_sin[1];
      cos_neg <= q_cos[1];
      last    <= cmd.last;
    end
  end

  assign out_ch.valid     = valid;
  assign out_ch.last      = last;
  assign out_ch.phase_out = phase;
  assign out_ch.sin_out   = sin_neg ? OB'(-sin_mag) : sin_mag;
  assign out_ch.cos_out   = cos_neg ? OB'(-cos_mag) : cos_mag;

endmodule
`default_nettype wire

// File: sim/nco_phase_and_iq_generator_checker.sv
// checker for the nco: predicts phase, cosine and sine per sample and compares output transfers
`timescale 1ns / 1ps
module nco_phase_and_iq_generator_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [nco_pkg::TUNE_BITS-1:0] cfg_wr_data,
  nco_in_if                             in_ch,
  nco_out_if                            out_ch,
  output int                            fail_count,
  output int                            outstanding,
  output int                            samples_checked
);

  localparam int ADDR_W = nco_pkg::TABLE_ADDR_BITS;
  localparam int QLEN = 1 << ADDR_W;
  localparam int OUT_W = nco_pkg::OUT_BITS;
  localparam int ACC_W = nco_pkg::PHASE_BITS;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint unsigned AMPL = (64'd1 << (OUT_W - 1)) - 64'd1;
  localparam logic [ADDR_W+1:0] COS_OFFSET = QLEN;

  typedef struct packed {
    logic [nco_pkg::PHASE_OUT_BITS-1:0] phase;
    logic [OUT_W-1:0]                   cos_v;
    logic [OUT_W-1:0]                   sin_v;
    logic                               last;
  } tone_sample_t;

  logic [OUT_W-1:0]  mag_table [0:QLEN];
  logic [ACC_W-1:0]  acc_phase;
  logic [ACC_W-1:0]  step_word;
  tone_sample_t      expected_samples[$];
  tone_sample_t      want;
  int                mismatches = 0;
  int                checked = 0;

  function automatic logic [OUT_W-1:0] quarter_wave_mag(int unsigned idx);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned horner;
    longint unsigned term;
    longint unsigned scaled;
    ang = (64'(idx) * HALF_PI) >> ADDR_W;
    ang_sq = (ang * ang) >> 30;
    horner = Q30_ONE;
    for (int n = 8; n >= 1; n--) begin
      term = ((ang_sq * horner) >> 30) / 64'((2 * n) * (2 * n + 1));
      horner = (term > Q30_ONE) ? 64'd0 : Q30_ONE - term;
    end
    scaled = ((((ang * horner) >> 30) * AMPL) + (Q30_ONE >> 1)) >> 30;
    if (scaled > AMPL) begin
      scaled = AMPL;
    end
    return scaled[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] wave_sine(logic [ADDR_W+1:0] k);
    logic [OUT_W-1:0] mag;
    mag = k[ADDR_W] ? mag_table[QLEN - int'(k[ADDR_W-1:0])] : mag_table[k[ADDR_W-1:0]];
    return k[ADDR_W+1] ? -mag : mag;
  endfunction

  task automatic predict_block(logic [nco_pkg::COUNT_BITS-1:0] count);
    int                n;
    logic [ADDR_W+1:0] k;
    tone_sample_t      s;
    n = (count > nco_pkg::MAX_BLOCK) ? nco_pkg::MAX_BLOCK : int'(count);
    for (int i = 0; i < n; i++) begin
      k = acc_phase[ACC_W-1 -: ADDR_W+2];
      s.phase = acc_phase[ACC_W-1 -: nco_pkg::PHASE_OUT_BITS];
      s.cos_v = wave_sine(k + COS_OFFSET);
      s.sin_v = wave_sine(k);
      s.last = (i == n - 1);
      expected_samples.push_back(s);
      acc_phase = acc_phase + step_word;
    end
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      mismatches++;
    end
  endtask

  initial begin
    for (int i = 0; i <= QLEN; i++) begin
      mag_table[i] = quarter_wave_mag(i);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      acc_phase = '0;
      step_word = '0;
      expected_samples.delete();
    end else begin
      if (cfg_wr_en) begin
        step_word = cfg_wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_block(in_ch.sample_count);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample transfer: phase_out %0d", out_ch.phase_out);
          mismatches++;
        end else begin
          want = expected_samples.pop_front();
          check_field("phase_out", want.phase, out_ch.phase_out);
          check_field("cos_out", want.cos_v, out_ch.cos_out);
          check_field("sin_out", want.sin_v, out_ch.sin_out);
          check_field("last", 16'(want.last), 16'(out_ch.last));
          checked++;
        end
      end
    end
    fail_count <= mismatches;
    outstanding <= expected_samples.size();
    samples_checked <= checked;
  end

endmodule

// File: sim/nco_phase_and_iq_generator_test.sv
// testbench top for the nco: block requests, tuning word writes, output stalls and verdict
`timescale 1ns / 1ps
module nco_phase_and_iq_generator_test;

  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 31;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [nco_pkg::TUNE_BITS-1:0] cfg_wr_data;
  int                            fail_count;
  int                            outstanding;
  int                            samples_checked;
  int                            requests_sent = 0;
  int                            tunings_written = 0;
  int                            quiet_cycles = 0;

  nco_in_if  in_ch ();
  nco_out_if out_ch ();

  nco_phase_and_iq_generator dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  nco_phase_and_iq_generator_checker iq_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .samples_checked (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("nco_phase_and_iq_generator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rx_pattern
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    mode = RX_OPEN;
    mode_left = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      tick++;
      case (mode)
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_LIGHT: begin
          out_ch.ready <= ($urandom_range(0, 3) != 0);
        end
        RX_HEAVY: begin
          out_ch.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          out_ch.ready <= ((tick % 6) < 2);
        end
      endcase
    end
  end

  function automatic logic [nco_pkg::COUNT_BITS-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return '0;
    end else if (r < 65) begin
      return nco_pkg::COUNT_BITS'($urandom_range(1, 8));
    end else if (r < 85) begin
      return nco_pkg::COUNT_BITS'($urandom_range(9, 32));
    end else if (r < 93) begin
      return nco_pkg::COUNT_BITS'($urandom_range(33, 64));
    end
    return nco_pkg::COUNT_BITS'($urandom_range(65, 127));
  endfunction

  task automatic request_block(logic [nco_pkg::COUNT_BITS-1:0] count);
    in_ch.valid <= 1'b1;
    in_ch.sample_count <= count;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic hold_off(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every predicted sample has come out, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tuning(logic [nco_pkg::TUNE_BITS-1:0] word);
    drain();
    cfg_wr_data <= word;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tunings_written++;
  endtask

  task automatic run_random_traffic(int items);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst && sent < items; b++) begin
        request_block(pick_count());
        sent++;
      end
      if ($urandom_range(0, 14) == 0) begin
        drain();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          hold_off(gap);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [nco_pkg::TUNE_BITS-1:0] word;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // tuning word still at its reset value
    request_block(1);
    request_block(0);
    request_block(64);

    set_tuning(32'h7FFF_FFFF);
    request_block(64);
    request_block(65);
    request_block(127);
    request_block(2);
    request_block(0);

    set_tuning(32'h8000_0000);
    request_block(3);
    request_block(64);

    set_tuning(32'hFFFF_FFFF);
    request_block(5);

    set_tuning(32'h0000_0001);
    request_block(1);

    // one full turn in 256 samples walks every quadrant
    set_tuning(32'h0100_0000);
    repeat (4) request_block(64);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          word = $urandom;
        end
        1: begin
          word = $urandom_range(1, 32'h0040_0000);
        end
        2: begin
          word = -$urandom_range(1, 32'h0040_0000);
        end
        default: begin
          word = $urandom & 32'hFFF0_0000;
        end
      endcase
      set_tuning(word);
      run_random_traffic(ITEMS_PER_PHASE);
    end

    drain();
    $display("covered %0d block requests and %0d checked samples over %0d tuning words,",
             requests_sent, samples_checked, tunings_written);
    $display("with counts from 0 to 127, both tuning word extremes and output stalls");
    if (fail_count == 0 && outstanding == 0) begin
      $display("nco_phase_and_iq_generator: match");
    end else begin
      $display("nco_phase_and_iq_generator: mismatch");
    end
    $finish;
  end

endmodule
